// File: design/cas_pkg.sv
`timescale 1ns / 1ps
package cas_pkg;

  localparam int NUM_CORES_DEF  = 4;
  localparam int NUM_LEAVES_DEF = 16;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_LEAF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRE_INTV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EWMA_W     = 3'd4;

  localparam logic ACT_FEEDBACK = 1'b0;
  localparam logic ACT_SELECT   = 1'b1;

  typedef struct packed {
    logic        action;
    logic [47:0] time_now;
    logic [3:0]  feedback_leaf;
    logic [1:0]  feedback_core;
    logic [16:0] feedback_metric;
    logic [3:0]  dest_leaf;
    logic [23:0] occupancy_core0;
    logic [23:0] occupancy_core1;
    logic [23:0] occupancy_core2;
    logic [23:0] occupancy_core3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  chosen_core;
    logic [16:0] chosen_congestion;
    logic        feedback_stored;
  } out_item_t;

  typedef struct packed {
    logic [23:0] queue_capacity;
    logic [39:0] dre_interval;
    logic [16:0] ewma_weight;
  } lane_cfg_t;

endpackage

// File: design/congestion_aware_uplink_select.sv
`timescale 1ns / 1ps
// Uplink selector for a leaf switch. A feedback item (action 0) stores a remote
// leaf's congestion metric for one core and answers in the next cycle with
// feedback_stored. A select item (action 1) runs one lane per core: a lane whose
// refresh interval has passed runs a 16-step divide of occupancy by capacity
// (skipped when occupancy reaches capacity), then a multiply and an add. The
// result of a select item is made by the min-of-max merge in S_MERGE once every
// lane is idle and is shown in S_OUT. One item is in flight at a time; the next
// is taken the cycle after the result has been accepted. Remote entries live in
// one small memory per core with a valid bit per entry cleared at reset.
module congestion_aware_uplink_select import cas_pkg::*; #(
  parameter int NUM_CORES  = NUM_CORES_DEF,
  parameter int NUM_LEAVES = NUM_LEAVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LW = $clog2(NUM_LEAVES);
  localparam int CW = $clog2(NUM_CORES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  in_item_t    item_r;
  out_item_t   out_r, out_nxt;
  logic [3:0]  own_r;
  logic [23:0] cap_r;
  logic [39:0] intv_r;
  logic [39:0] tmo_r;
  logic [16:0] w_r;
  logic [NUM_LEAVES-1:0][NUM_CORES-1:0] valid_r;
  logic [NUM_CORES-1:0][16:0] rem_r;

  logic        in_acc;
  logic        fb_store;
  logic [16:0] fb_metric;
  logic [LW-1:0] fb_leaf, rd_leaf;
  logic        dst_ok;
  lane_cfg_t   lane_cfg;
  logic [3:0][23:0] occ_all;
  logic [NUM_CORES-1:0]       lane_busy;
  logic [NUM_CORES-1:0][16:0] loc;
  logic [NUM_CORES-1:0][16:0] rem_q;
  logic [NUM_CORES-1:0][64:0] rd_data;
  logic [1:0]  best_core;
  logic [16:0] best_val;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  assign fb_leaf   = LW'(in_data.feedback_leaf);
  assign rd_leaf   = LW'(item_r.dest_leaf);
  assign fb_metric = (in_data.feedback_metric > ONE_Q16) ? ONE_Q16 : in_data.feedback_metric;
  assign fb_store  = in_acc && (in_data.action == ACT_FEEDBACK)
                     && (in_data.feedback_leaf != own_r)
                     && (7'(in_data.feedback_leaf) < 7'(NUM_LEAVES))
                     && (3'(in_data.feedback_core) < 3'(NUM_CORES));
  assign dst_ok    = (7'(item_r.dest_leaf) < 7'(NUM_LEAVES));

  assign lane_cfg = '{queue_capacity: cap_r, dre_interval: intv_r, ewma_weight: w_r};
  assign occ_all  = {item_r.occupancy_core3, item_r.occupancy_core2,
                     item_r.occupancy_core1, item_r.occupancy_core0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r  <= 4'd0;
      cap_r  <= 24'd65536;
      intv_r <= 40'd1000000;
      tmo_r  <= 40'd100000000;
      w_r    <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_LEAF:   own_r  <= cfg_wdata[3:0];
        REG_QUEUE_CAP:  cap_r  <= cfg_wdata[23:0];
        REG_DRE_INTV:   intv_r <= cfg_wdata;
        REG_FB_TIMEOUT: tmo_r  <= cfg_wdata;
        REG_EWMA_W:     w_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < NUM_CORES; c++) begin : g_core
    cas_ram #(.WIDTH(65), .DEPTH(NUM_LEAVES)) u_ram (
      .clk   (clk),
      .we    (fb_store && (CW'(in_data.feedback_core) == CW'(c))),
      .waddr (fb_leaf),
      .wdata ({fb_metric, in_data.time_now}),
      .raddr (rd_leaf),
      .rdata (rd_data[c])
    );

    cas_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (state_r == S_START),
      .now    (item_r.time_now),
      .occ    (occ_all[c]),
      .cfg    (lane_cfg),
      .busy   (lane_busy[c]),
      .metric (loc[c])
    );

    assign rem_q[c] = (dst_ok && valid_r[rd_leaf][c]
                       && ((item_r.time_now - rd_data[c][47:0]) < {8'd0, tmo_r}))
                      ? rd_data[c][64:48] : 17'd0;
  end

  cas_merge #(.NUM_CORES(NUM_CORES)) u_merge (
    .loc       (loc),
    .rem       (rem_r),
    .best_core (best_core),
    .best_val  (best_val)
  );

  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_FEEDBACK) begin
            out_nxt   = '{chosen_core: 2'd0, chosen_congestion: 17'd0,
                          feedback_stored: fb_store};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (lane_busy == '0) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        out_nxt   = '{chosen_core: best_core, chosen_congestion: best_val,
                      feedback_stored: 1'b0};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (fb_store) begin
        valid_r[fb_leaf][CW'(in_data.feedback_core)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    rem_r <= rem_q;
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  a_fb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.feedback_stored) |->
      (out_data.chosen_core == 2'd0 && out_data.chosen_congestion == 17'd0))
    else $error("feedback result carries a selection");

  a_cong_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.chosen_congestion <= ONE_Q16))
    else $error("congestion above one");

  a_merge_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (lane_busy == '0))
    else $error("merge while a lane is busy");

endmodule

// File: design/cas_ram.sv
`timescale 1ns / 1ps
module cas_ram import cas_pkg::*; #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/cas_lane.sv
`timescale 1ns / 1ps
module cas_lane import cas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] now,
  input  logic [23:0] occ,
  input  lane_cfg_t   cfg,
  output logic        busy,
  output logic [16:0] metric
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_DIV  = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_SUM  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic        started_r, started_nxt;
  logic [16:0] est_r, est_nxt;
  logic [47:0] refresh_r, refresh_nxt;
  logic [47:0] now_r, now_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] util_r, util_nxt;
  logic [33:0] p1_r, p1_nxt, p2_r, p2_nxt;

  logic [47:0] age;
  logic [23:0] cap_eff;
  logic [16:0] w_eff;
  logic [24:0] rem2;
  logic        qbit;
  logic [34:0] sum;

  assign cap_eff = (cfg.queue_capacity == 24'd0) ? 24'd1 : cfg.queue_capacity;
  assign w_eff   = (cfg.ewma_weight > ONE_Q16) ? ONE_Q16 : cfg.ewma_weight;
  assign age     = now - refresh_r;
  assign rem2    = {rem_r, 1'b0};
  assign qbit    = (rem2 >= {1'b0, cap_eff});
  assign sum     = {1'b0, p1_r} + {1'b0, p2_r};

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    est_nxt     = est_r;
    refresh_nxt = refresh_r;
    now_nxt     = now_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    util_nxt    = util_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          if (!started_r) begin
            started_nxt = 1'b1;
            refresh_nxt = now;
            est_nxt     = 17'd0;
          end else if (age >= {8'd0, cfg.dre_interval}) begin
            now_nxt = now;
            if (occ >= cap_eff) begin
              util_nxt  = ONE_Q16;
              state_nxt = L_MUL;
            end else begin
              rem_nxt   = occ;
              quo_nxt   = 16'd0;
              cnt_nxt   = 4'd0;
              state_nxt = L_DIV;
            end
          end
        end
      end
      L_DIV: begin
        rem_nxt = qbit ? 24'(rem2 - {1'b0, cap_eff}) : rem2[23:0];
        quo_nxt = {quo_r[14:0], qbit};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          util_nxt  = {1'b0, quo_nxt};
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        p1_nxt    = w_eff * util_r;
        p2_nxt    = (ONE_Q16 - w_eff) * est_r;
        state_nxt = L_SUM;
      end
      L_SUM: begin
        est_nxt     = sum[32:16];
        refresh_nxt = now_r;
        state_nxt   = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= L_IDLE;
      started_r <= 1'b0;
      est_r     <= 17'd0;
      refresh_r <= 48'd0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      est_r     <= est_nxt;
      refresh_r <= refresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    util_r <= util_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
  end

  assign busy   = (state_r != L_IDLE);
  assign metric = est_r;

endmodule

// File: design/cas_merge.sv
`timescale 1ns / 1ps
module cas_merge import cas_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic [NUM_CORES-1:0][16:0] loc,
  input  logic [NUM_CORES-1:0][16:0] rem,
  output logic [1:0]                 best_core,
  output logic [16:0]                best_val
);

  logic [NUM_CORES-1:0][16:0] path;

  always_comb begin
    best_core = 2'd0;
    best_val  = 17'd0;
    for (int c = 0; c < NUM_CORES; c++) begin
      path[c] = (loc[c] > rem[c]) ? loc[c] : rem[c];
      if (c == 0 || path[c] < best_val) begin
        best_val  = path[c];
        best_core = 2'(c);
      end
    end
  end

endmodule
